// ===== rtl/spp_dly_pkg.sv =====
// Package for the stereo ping-pong delay: payload structs, register map, helpers.
// No dependencies.
package spp_dly_pkg;

  localparam int SampleW = 24;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
  } out_item_t;

  // register indexes
  localparam logic [2:0] REG_MIX  = 3'd0;
  localparam logic [2:0] REG_FB   = 3'd1;
  localparam logic [2:0] REG_WID  = 3'd2;
  localparam logic [2:0] REG_PP   = 3'd3;
  localparam logic [2:0] REG_HP   = 3'd4;
  localparam logic [2:0] REG_LP   = 3'd5;
  localparam logic [2:0] REG_LEN  = 3'd6;

  localparam logic [16:0] Unity = 17'd65536;
  localparam logic [15:0] FbMax = 16'd62259;

  // per-lane coefficient bundle
  typedef struct packed {
    logic [15:0] fb_gain;
    logic [15:0] hp_coeff;
    logic [15:0] lp_coeff;
  } lane_cfg_t;

  // round (add half, floor) by 2^16 and saturate to a sample
  function automatic logic signed [SampleW-1:0] rnd_sat16(input logic signed [63:0] v);
    logic signed [63:0] t;
    begin
      t = (v + 64'sd32768) >>> 16;
      if (t > 64'sd8388607) rnd_sat16 = 24'sh7fffff;
      else if (t < -64'sd8388608) rnd_sat16 = 24'sh800000;
      else rnd_sat16 = t[SampleW-1:0];
    end
  endfunction

  function automatic logic signed [SampleW-1:0] rnd_sat17(input logic signed [63:0] v);
    logic signed [63:0] t;
    begin
      t = (v + 64'sd65536) >>> 17;
      if (t > 64'sd8388607) rnd_sat17 = 24'sh7fffff;
      else if (t < -64'sd8388608) rnd_sat17 = 24'sh800000;
      else rnd_sat17 = t[SampleW-1:0];
    end
  endfunction

  function automatic logic signed [SampleW-1:0] sat_sum(input logic signed [SampleW:0] v);
    begin
      if (v > 25'sd8388607) sat_sum = 24'sh7fffff;
      else if (v < -25'sd8388608) sat_sum = 24'sh800000;
      else sat_sum = v[SampleW-1:0];
    end
  endfunction

endpackage

// ===== rtl/spp_dly_ram.sv =====
// Generic single-port-write RAM with registered read.
// No dependencies.
module spp_dly_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/spp_dly_lane.sv =====
// One feedback lane: gain, high-pass, low-pass, ring write value.
// Depends on spp_dly_pkg. Steps through scale, high-pass and low-pass over three phases.
module spp_dly_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spp_dly_pkg::lane_cfg_t            cfg,
  input  logic [1:0]                        phase,
  input  logic                              busy,
  input  logic signed [spp_dly_pkg::SampleW-1:0] fb_src,
  input  logic signed [spp_dly_pkg::SampleW-1:0] dry,
  output logic signed [spp_dly_pkg::SampleW-1:0] ring_wr
);
  import spp_dly_pkg::*;

  logic signed [SampleW-1:0] last_in_r, hp_r, lp_r, fb_r;
  logic signed [SampleW-1:0] hp_nxt, lp_nxt, fb_nxt;
  logic signed [SampleW+1:0] hp_arg;

  // phase 0: feedback scale; 1: high-pass; 2: low-pass
  assign fb_nxt = rnd_sat16($signed({1'b0, cfg.fb_gain}) * 64'(fb_src));
  assign hp_arg = 26'(hp_r) + 26'(fb_r) - 26'(last_in_r);
  assign hp_nxt = rnd_sat16($signed({1'b0, cfg.hp_coeff}) * 64'(hp_arg));
  assign lp_nxt = rnd_sat16($signed({1'b0, cfg.lp_coeff}) * 64'(lp_r)
                  + (64'sd65536 - 64'(cfg.lp_coeff)) * 64'(hp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_in_r <= '0;
      hp_r      <= '0;
      lp_r      <= '0;
      fb_r      <= '0;
    end else if (busy) begin
      case (phase)
        2'd0: fb_r <= fb_nxt;
        2'd1: begin
          hp_r      <= hp_nxt;
          last_in_r <= fb_r;
        end
        2'd2: lp_r <= lp_nxt;
        default: ;
      endcase
    end
  end

  assign ring_wr = sat_sum(25'(dry) + 25'(lp_r));
endmodule

// ===== rtl/stereo_ping_pong_delay_unit.sv =====
// Stereo ping-pong delay, top level: registers, rings, two lanes, mixer.
// A request is taken only in idle; the frame then steps through the RUN phases
// (scale, high-pass, low-pass, ring write) and the result state, which holds
// while out_stall is high, and returns to idle before the next request is taken.
// Reset (rst_n low, synchronous) loads register defaults, then a clearing
// pass over all MAX_DELAY addresses zeroes both rings; a delay_length write repeats it.
// Depends on spp_dly_pkg, spp_dly_ram, spp_dly_lane.
module stereo_ping_pong_delay_unit #(
  parameter int MAX_DELAY = 131072
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  spp_dly_pkg::in_item_t   in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output spp_dly_pkg::out_item_t  out_data,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [4:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import spp_dly_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r;
  logic [16:0] mix_r, wid_r;
  logic [15:0] fb_r, hp_r, lp_r;
  logic        pp_r;
  logic [17:0] len_r;
  logic [AW-1:0] ptr_r, clr_r;
  logic [1:0] ph_r;
  in_item_t in_r;
  out_item_t out_r;
  logic signed [SampleW-1:0] dl, dr, wl_r, wr_r;
  logic signed [SampleW-1:0] wl_ring, wr_ring;
  logic wr_cfg, len_wr, we;
  logic [2:0] reg_idx;
  logic [AW-1:0] waddr;
  logic [SampleW-1:0] wdl, wdr;
  logic [16:0] m_eff, w_eff;
  logic [15:0] g_eff;
  logic [18:0] len_eff;
  lane_cfg_t cfg_l;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[4:2];
  assign wr_cfg = cfg_psel && cfg_penable && cfg_pwrite;
  assign len_wr = wr_cfg && (reg_idx == REG_LEN);

  // register read
  always_comb begin
    case (reg_idx)
      REG_MIX: cfg_prdata = 32'(mix_r);
      REG_FB:  cfg_prdata = 32'(fb_r);
      REG_WID: cfg_prdata = 32'(wid_r);
      REG_PP:  cfg_prdata = 32'(pp_r);
      REG_HP:  cfg_prdata = 32'(hp_r);
      REG_LP:  cfg_prdata = 32'(lp_r);
      REG_LEN: cfg_prdata = 32'(len_r);
      default: cfg_prdata = '0;
    endcase
  end

  // clamps
  assign m_eff = (mix_r > Unity) ? Unity : mix_r;
  assign w_eff = (wid_r > Unity) ? Unity : wid_r;
  assign g_eff = (fb_r > FbMax) ? FbMax : fb_r;
  assign len_eff = (len_r == 18'd0) ? 19'd1 :
                   (32'(len_r) > MAX_DELAY) ? 19'(MAX_DELAY) : 19'(len_r);
  assign cfg_l = '{fb_gain: g_eff, hp_coeff: hp_r, lp_coeff: lp_r};

  // rings
  assign we    = (state_r == ST_CLR) || (state_r == ST_RUN && ph_r == 2'd3);
  assign waddr = (state_r == ST_CLR) ? clr_r : ptr_r;
  assign wdl   = (state_r == ST_CLR) ? '0 : wl_ring;
  assign wdr   = (state_r == ST_CLR) ? '0 : wr_ring;

  spp_dly_ram #(.Width(SampleW), .Depth(MAX_DELAY)) u_ram_l (
    .clk, .we, .waddr, .wdata(wdl), .raddr(ptr_r), .rdata(dl));
  spp_dly_ram #(.Width(SampleW), .Depth(MAX_DELAY)) u_ram_r (
    .clk, .we, .waddr, .wdata(wdr), .raddr(ptr_r), .rdata(dr));

  // lanes; ping-pong swaps the feedback sources
  spp_dly_lane u_lane_l (
    .clk, .rst_n, .cfg(cfg_l), .phase(ph_r), .busy(state_r == ST_RUN),
    .fb_src(pp_r ? dr : dl), .dry(in_r.left_in), .ring_wr(wl_ring));
  spp_dly_lane u_lane_r (
    .clk, .rst_n, .cfg(cfg_l), .phase(ph_r), .busy(state_r == ST_RUN),
    .fb_src(pp_r ? dl : dr), .dry(in_r.right_in), .ring_wr(wr_ring));

  // merge: width blend (phase 0) then dry/wet mix (phase 1)
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN && ph_r == 2'd0) begin
      wl_r <= rnd_sat17(64'(dl) * 64'(18'(Unity) * 2 - 18'(w_eff)) + 64'(dr) * 64'(w_eff));
      wr_r <= rnd_sat17(64'(dr) * 64'(18'(Unity) * 2 - 18'(w_eff)) + 64'(dl) * 64'(w_eff));
    end
    if (state_r == ST_RUN && ph_r == 2'd1) begin
      out_r.left_out  <= rnd_sat16(64'(in_r.left_in) * 64'(Unity - m_eff)
                                   + 64'(wl_r) * 64'(m_eff));
      out_r.right_out <= rnd_sat16(64'(in_r.right_in) * 64'(Unity - m_eff)
                                   + 64'(wr_r) * 64'(m_eff));
    end
    if (in_valid && !in_stall) in_r <= in_data;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      ptr_r <= '0;
      ph_r <= '0;
      mix_r <= 17'd32768;
      fb_r  <= 16'd32768;
      wid_r <= '0;
      pp_r  <= 1'b1;
      hp_r  <= 16'd65000;
      lp_r  <= 16'd4000;
      len_r <= 18'd24000;
    end else begin
      if (wr_cfg) begin
        case (reg_idx)
          REG_MIX: mix_r <= cfg_pwdata[16:0];
          REG_FB:  fb_r  <= cfg_pwdata[15:0];
          REG_WID: wid_r <= cfg_pwdata[16:0];
          REG_PP:  pp_r  <= cfg_pwdata[0];
          REG_HP:  hp_r  <= cfg_pwdata[15:0];
          REG_LP:  lp_r  <= cfg_pwdata[15:0];
          REG_LEN: len_r <= cfg_pwdata[17:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAX_DELAY - 1) state_r <= ST_IDLE;
        end
        ST_IDLE: if (in_valid) begin
          state_r <= ST_RUN;
          ph_r <= '0;
        end
        ST_RUN: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 2'd3) begin
            state_r <= ST_OUT;
            ptr_r <= (20'(ptr_r) + 20'd1 >= 20'(len_eff)) ? '0 : ptr_r + 1'b1;
          end
        end
        ST_OUT: if (!out_stall) state_r <= ST_IDLE;
        default: state_r <= ST_CLR;
      endcase
      if (len_wr) begin
        state_r <= ST_CLR;
        clr_r <= '0;
        ptr_r <= '0;
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_ptr_rng: assert property (@(posedge clk) disable iff (!rst_n)
    20'(ptr_r) < 20'(len_eff) || state_r == ST_CLR || $past(wr_cfg))
    else $error("pointer beyond length");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> in_stall) else $error("accept while busy");
endmodule
